// ===== rtl/hcw_pkg.sv =====
// Shared types, constants and step functions of the HSV color wheel pipeline.
`timescale 1ns / 1ps
`default_nettype none
package hcw_pkg;

    localparam int MAX_SIDE      = 512;
    localparam int PIX_W         = 9;
    localparam int CFG_W         = 10;
    localparam int SIDE_W        = $clog2(MAX_SIDE + 1);
    localparam int SIDE_MIN      = 2;
    localparam int SIDE_RESET    = (MAX_SIDE < 256) ? MAX_SIDE : 256;

    // |2*pixel - side| and the rounding numerator
    localparam int MAG_W         = (PIX_W + 1 > SIDE_W) ? PIX_W + 1 : SIDE_W;
    localparam int NUM_W         = MAG_W + 16;
    localparam int QW            = 15;          // offset magnitude bits, also root bits
    localparam int OFF_W         = 16;          // Q2.14
    localparam int STEPS_PER_STG = 2;

    localparam int DIV_STG       = (QW + STEPS_PER_STG - 1) / STEPS_PER_STG;
    localparam int SQRT_STG      = (QW + STEPS_PER_STG - 1) / STEPS_PER_STG;
    localparam int CORDIC_N      = 16;
    localparam int CORDIC_STG    = (CORDIC_N + STEPS_PER_STG - 1) / STEPS_PER_STG;

    localparam int NORM_LAT      = DIV_STG + 2;
    localparam int SAT_LAT       = SQRT_STG + 2;
    localparam int CORDIC_LAT    = CORDIC_STG + 2;
    localparam int COLOR_LAT     = 5;
    localparam int PIPE_LAT      = NORM_LAT + SAT_LAT + COLOR_LAT;

    localparam int SQ_REM_W      = QW + 4;
    localparam int CW            = 27;          // CORDIC x/y
    localparam int ZW            = 22;          // angle, 1/4096 degree
    localparam int HUE_W         = 15;          // 1/64 degree
    localparam int F_W           = 12;
    localparam int C_W           = 27;          // channel level, full scale D
    localparam int LVL_W         = 12;

    localparam int HALF_TURN     = 180 * 4096;
    localparam int FULL_TURN     = 360 * 4096;
    localparam int HUE_TURN      = 360 * 64;
    localparam int SECTOR        = 3840;
    localparam int ONE_Q15       = 32768;
    localparam int D_FULL        = ONE_Q15 * SECTOR;
    localparam int DIV15_MUL     = 2185;        // floor(x/15) == (x*2185)>>15 for x < 4096
    localparam int RIM_LIMIT     = 32440;       // s*100 > 99*32768  <=>  s > 32440
    localparam int ALPHA_SCALE   = 25500;

    localparam int ATAN_TAB [CORDIC_N] = '{
        184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QW-1:0]    quo;
    } div_state_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [QW-1:0]       root;
    } sqrt_state_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_vec_t;

    // one restoring division step for quotient bit b
    function automatic div_state_t div_step(input div_state_t st, input logic [SIDE_W:0] d2,
                                            input int b);
        div_state_t       w;
        logic [NUM_W-1:0] sh;
        w  = st;
        sh = NUM_W'(d2) << b;
        if (st.rem >= sh)
        begin
            w.rem    = st.rem - sh;
            w.quo[b] = 1'b1;
        end
        return w;
    endfunction

    // one digit of the bitwise integer square root
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t st, input logic [1:0] pair);
        sqrt_state_t         w;
        logic [SQ_REM_W-1:0] r2;
        logic [SQ_REM_W-1:0] trial;
        r2    = {st.rem[SQ_REM_W-3:0], pair};
        trial = SQ_REM_W'({st.root, 2'b01});
        if (r2 >= trial)
        begin
            w.rem  = r2 - trial;
            w.root = {st.root[QW-2:0], 1'b1};
        end
        else
        begin
            w.rem  = r2;
            w.root = {st.root[QW-2:0], 1'b0};
        end
        return w;
    endfunction

    // one vectoring rotation
    function automatic cordic_vec_t cordic_step(input cordic_vec_t v, input int i);
        cordic_vec_t          w;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        x  = v.x;
        y  = v.y;
        xs = x >>> i;
        ys = y >>> i;
        if (!y[CW-1])
        begin
            w.x = x + ys;
            w.y = y - xs;
            w.z = v.z + ZW'(ATAN_TAB[i]);
        end
        else
        begin
            w.x = x - ys;
            w.y = y + xs;
            w.z = v.z - ZW'(ATAN_TAB[i]);
        end
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/hsv_color_wheel_pixel.sv =====
// Top level of the HSV color wheel pixel generator.
//
// Usage: one pixel coordinate word enters on pix (pixel_x, pixel_y) with
// pix_valid/pix_ready; one RGBA word leaves on rgba with rgba_valid/rgba_ready.
// The side of the square image is written on cfg_data with cfg_valid; the
// port is always ready. Write it only while no pixel is in flight.
//
// Throughput: one pixel per cycle unless the output stalls. The depth is
// set by the offset divider (15 quotient bits), then in parallel the
// square root (15 digits) and the 16-step CORDIC, two iterations per stage,
// then 5 color stages.
//
// Stall: the whole pipeline holds while rgba_valid is high and rgba_ready is
// low; pix_ready is low only then, and nothing is dropped or repeated.
// Reset: clears all valid bits and sets the side to 256.
`timescale 1ns / 1ps
`default_nettype none
module hsv_color_wheel_pixel (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [hcw_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        pix_valid,
    output logic                        pix_ready,
    input  hcw_pkg::pixel_t             pix,
    output logic                        rgba_valid,
    input  logic                        rgba_ready,
    output hcw_pkg::rgba_t              rgba
);
    import hcw_pkg::*;

    logic [SIDE_W-1:0]   side_reg;
    logic [SIDE_W-1:0]   side_next;
    logic [PIPE_LAT-1:0] vld_reg;
    logic                en;
    logic signed [OFF_W-1:0] dx;
    logic signed [OFF_W-1:0] dy;
    logic [QW-1:0]       sat;
    logic                outside;
    logic [HUE_W-1:0]    hue;

    // side is clamped once when written
    always_comb
    begin
        if (int'(cfg_data) < SIDE_MIN)
            side_next = SIDE_W'(SIDE_MIN);
        else if (int'(cfg_data) > MAX_SIDE)
            side_next = SIDE_W'(MAX_SIDE);
        else
            side_next = SIDE_W'(cfg_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= SIDE_W'(SIDE_RESET);
        else if (cfg_valid && cfg_ready)
            side_reg <= side_next;
    end

    // global advance: the pipeline moves unless a finished word is held
    assign en        = !vld_reg[PIPE_LAT-1] || rgba_ready;
    assign pix_ready = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LAT-2:0], pix_valid};
    end

    hcw_norm u_norm_x (
        .clk  (clk),
        .en   (en),
        .side (side_reg),
        .pix  (pix.pixel_x),
        .off  (dx)
    );

    hcw_norm u_norm_y (
        .clk  (clk),
        .en   (en),
        .side (side_reg),
        .pix  (pix.pixel_y),
        .off  (dy)
    );

    // saturation and hue run side by side with equal depth
    hcw_sat u_sat (
        .clk     (clk),
        .en      (en),
        .dx      (dx),
        .dy      (dy),
        .sat     (sat),
        .outside (outside)
    );

    hcw_cordic u_cordic (
        .clk (clk),
        .en  (en),
        .dx  (dx),
        .dy  (dy),
        .hue (hue)
    );

    hcw_color u_color (
        .clk     (clk),
        .en      (en),
        .hue     (hue),
        .sat     (sat),
        .outside (outside),
        .rgba    (rgba)
    );

    assign rgba_valid = vld_reg[PIPE_LAT-1];

endmodule
`default_nettype wire

// ===== rtl/hcw_norm.sv =====
// Center offset of one coordinate, normalized by half the side, Q2.14.
`timescale 1ns / 1ps
`default_nettype none
module hcw_norm (
    input  logic                              clk,
    input  logic                              en,
    input  logic [hcw_pkg::SIDE_W-1:0]        side,
    input  logic [hcw_pkg::PIX_W-1:0]         pix,
    output logic signed [hcw_pkg::OFF_W-1:0]  off
);
    import hcw_pkg::*;

    localparam logic signed [OFF_W-1:0] OFF_MAX = 16'sh7FFF;
    localparam logic signed [OFF_W-1:0] OFF_MIN = 16'sh8000;

    logic signed [MAG_W:0]   diff;
    logic [MAG_W-1:0]        mag;
    logic [SIDE_W:0]         d2;
    div_state_t              st0_next;
    logic                    ovf0_next;
    div_state_t              st_reg  [0:DIV_STG];
    div_state_t              st_next [1:DIV_STG];
    logic                    neg_reg [0:DIV_STG];
    logic                    ovf_reg [0:DIV_STG];
    logic signed [OFF_W-1:0] off_next;
    logic signed [OFF_W-1:0] off_reg;

    // rounding numerator |2p - S| * 32768 + S over divisor 2S
    always_comb
    begin
        d2        = {side, 1'b0};
        diff      = $signed({1'b0, MAG_W'({pix, 1'b0})}) - $signed({1'b0, MAG_W'(side)});
        mag       = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
        st0_next.rem = NUM_W'({mag, {QW{1'b0}}}) + NUM_W'(side);
        st0_next.quo = '0;
        ovf0_next = st0_next.rem >= NUM_W'({d2, {QW{1'b0}}});
    end

    always_comb
    begin
        for (int k = 1; k <= DIV_STG; k++)
        begin
            st_next[k] = st_reg[k-1];
            for (int j = 0; j < STEPS_PER_STG; j++)
            begin
                if ((k - 1) * STEPS_PER_STG + j < QW)
                    st_next[k] = div_step(st_next[k], d2, QW - 1 - ((k - 1) * STEPS_PER_STG + j));
            end
        end
    end

    always_comb
    begin
        if (ovf_reg[DIV_STG])
            off_next = neg_reg[DIV_STG] ? OFF_MIN : OFF_MAX;
        else if (neg_reg[DIV_STG])
            off_next = -$signed({1'b0, st_reg[DIV_STG].quo});
        else
            off_next = $signed({1'b0, st_reg[DIV_STG].quo});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]  <= st0_next;
            neg_reg[0] <= diff[MAG_W];
            ovf_reg[0] <= ovf0_next;
            for (int k = 1; k <= DIV_STG; k++)
            begin
                st_reg[k]  <= st_next[k];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
            off_reg <= off_next;
        end
    end

    assign off = off_reg;

endmodule
`default_nettype wire

// ===== rtl/hcw_sat.sv =====
// Saturation: squared radius and bitwise square root, Q0.15.
`timescale 1ns / 1ps
`default_nettype none
module hcw_sat (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [hcw_pkg::OFF_W-1:0]  dx,
    input  logic signed [hcw_pkg::OFF_W-1:0]  dy,
    output logic [hcw_pkg::QW-1:0]            sat,
    output logic                              outside
);
    import hcw_pkg::*;

    logic signed [31:0]   px;
    logic signed [31:0]   py;
    logic [30:0]          sqx_reg;
    logic [30:0]          sqy_reg;
    logic [31:0]          sum;
    sqrt_state_t          st_reg  [0:SQRT_STG];
    sqrt_state_t          st_next [1:SQRT_STG];
    logic [2*QW-3:0]      rad_reg [0:SQRT_STG];
    logic                 out_reg [0:SQRT_STG];
    logic [2*QW-1:0]      rad4;

    always_comb
    begin
        px  = dx * dx;
        py  = dy * dy;
        sum = 32'(sqx_reg) + 32'(sqy_reg);
    end

    // radicand 4*sum; only sums below 2^28 lie inside the wheel
    always_comb
    begin
        for (int k = 1; k <= SQRT_STG; k++)
        begin
            rad4       = {rad_reg[k-1], 2'b00};
            st_next[k] = st_reg[k-1];
            for (int j = 0; j < STEPS_PER_STG; j++)
            begin
                if ((k - 1) * STEPS_PER_STG + j < QW)
                    st_next[k] = sqrt_step(st_next[k],
                        rad4[2 * (QW - 1 - ((k - 1) * STEPS_PER_STG + j)) +: 2]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg    <= px[30:0];
            sqy_reg    <= py[30:0];
            st_reg[0]  <= '0;
            rad_reg[0] <= sum[2*QW-3:0];
            out_reg[0] <= sum[31:2*QW-2] != '0;
            for (int k = 1; k <= SQRT_STG; k++)
            begin
                st_reg[k]  <= st_next[k];
                rad_reg[k] <= rad_reg[k-1];
                out_reg[k] <= out_reg[k-1];
            end
        end
    end

    assign sat     = st_reg[SQRT_STG].root;
    assign outside = out_reg[SQRT_STG];

endmodule
`default_nettype wire

// ===== rtl/hcw_cordic.sv =====
// Hue: CORDIC vectoring angle, wrapped and rounded to 1/64 degree.
`timescale 1ns / 1ps
`default_nettype none
module hcw_cordic (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [hcw_pkg::OFF_W-1:0]  dx,
    input  logic signed [hcw_pkg::OFF_W-1:0]  dy,
    output logic [hcw_pkg::HUE_W-1:0]         hue
);
    import hcw_pkg::*;

    cordic_vec_t          v0_next;
    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;
    cordic_vec_t          st_reg  [0:CORDIC_STG];
    cordic_vec_t          st_next [1:CORDIC_STG];
    logic                 ctr_reg [0:CORDIC_STG];
    logic signed [ZW-1:0] zw;
    logic signed [ZW-1:0] zr;
    logic [HUE_W-1:0]     hue_next;
    logic [HUE_W-1:0]     hue_reg;

    // left half plane turned by 180 degrees
    always_comb
    begin
        xe = CW'(dx) <<< 8;
        ye = CW'(dy) <<< 8;
        if (dx < 0)
        begin
            v0_next.x = -xe;
            v0_next.y = -ye;
            v0_next.z = ZW'(HALF_TURN);
        end
        else
        begin
            v0_next.x = xe;
            v0_next.y = ye;
            v0_next.z = '0;
        end
    end

    always_comb
    begin
        for (int k = 1; k <= CORDIC_STG; k++)
        begin
            st_next[k] = st_reg[k-1];
            for (int j = 0; j < STEPS_PER_STG; j++)
            begin
                if ((k - 1) * STEPS_PER_STG + j < CORDIC_N)
                    st_next[k] = cordic_step(st_next[k], (k - 1) * STEPS_PER_STG + j);
            end
        end
    end

    always_comb
    begin
        zw = st_reg[CORDIC_STG].z;
        if (zw < 0)
            zw = zw + ZW'(FULL_TURN);
        zr = (zw + ZW'(32)) >>> 6;
        if (ctr_reg[CORDIC_STG])
            hue_next = '0;
        else if (zr >= ZW'(HUE_TURN))
            hue_next = HUE_W'(zr - ZW'(HUE_TURN));
        else
            hue_next = HUE_W'(zr);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]  <= v0_next;
            ctr_reg[0] <= (dx == 0) && (dy == 0);
            for (int k = 1; k <= CORDIC_STG; k++)
            begin
                st_reg[k]  <= st_next[k];
                ctr_reg[k] <= ctr_reg[k-1];
            end
            hue_reg <= hue_next;
        end
    end

    assign hue = hue_reg;

endmodule
`default_nettype wire

// ===== rtl/hcw_color.sv =====
// HSV to RGB with value 1, rim alpha ramp and outside masking.
`timescale 1ns / 1ps
`default_nettype none
module hcw_color (
    input  logic                        clk,
    input  logic                        en,
    input  logic [hcw_pkg::HUE_W-1:0]   hue,
    input  logic [hcw_pkg::QW-1:0]      sat,
    input  logic                        outside,
    output hcw_pkg::rgba_t              rgba
);
    import hcw_pkg::*;

    // stage 0: sector and fraction
    logic [17:0]      sprod;
    logic [2:0]       sec;
    logic [HUE_W-1:0] fw;
    sector_t          sec0_reg;
    logic [F_W-1:0]   f0_reg;
    logic [QW-1:0]    s0_reg;
    logic             out0_reg;

    // stage 1: products
    logic [15:0]      am;
    sector_t          sec1_reg;
    logic [C_W-1:0]   sf1_reg;
    logic [C_W-1:0]   sg1_reg;
    logic [C_W-1:0]   p1_reg;
    logic [15:0]      am1_reg;
    logic             rim1_reg;
    logic             out1_reg;

    // stage 2: channel levels
    logic [C_W-1:0]   q2;
    logic [C_W-1:0]   t2;
    logic [C_W-1:0]   cr;
    logic [C_W-1:0]   cg;
    logic [C_W-1:0]   cb;
    logic [C_W-1:0]   cr2_reg;
    logic [C_W-1:0]   cg2_reg;
    logic [C_W-1:0]   cb2_reg;
    logic [30:0]      ap2_reg;
    logic             rim2_reg;
    logic             out2_reg;

    // stage 3: scale by 255 / 2^23
    logic [34:0]      mr;
    logic [34:0]      mg;
    logic [34:0]      mb;
    logic [15:0]      araw;
    logic [LVL_W-1:0] lr3_reg;
    logic [LVL_W-1:0] lg3_reg;
    logic [LVL_W-1:0] lb3_reg;
    logic [7:0]       a3_reg;
    logic             out3_reg;

    // stage 4: divide by 15
    logic [23:0]      nr;
    logic [23:0]      ng;
    logic [23:0]      nb;
    rgba_t            rgba_next;
    rgba_t            rgba_reg;

    always_comb
    begin
        sprod = 18'(hue[HUE_W-1:8]) * 18'(DIV15_MUL);
        sec   = sprod[17:15];
        fw    = hue - HUE_W'(32'(sec) * SECTOR);
        am    = 16'(ONE_Q15) - 16'(s0_reg);
    end

    always_comb
    begin
        q2 = C_W'(D_FULL) - sf1_reg;
        t2 = C_W'(D_FULL) - sg1_reg;
        case (sec1_reg)
            SEC_RY:
            begin
                cr = C_W'(D_FULL); cg = t2; cb = p1_reg;
            end
            SEC_YG:
            begin
                cr = q2; cg = C_W'(D_FULL); cb = p1_reg;
            end
            SEC_GC:
            begin
                cr = p1_reg; cg = C_W'(D_FULL); cb = t2;
            end
            SEC_CB:
            begin
                cr = p1_reg; cg = q2; cb = C_W'(D_FULL);
            end
            SEC_BM:
            begin
                cr = t2; cg = p1_reg; cb = C_W'(D_FULL);
            end
            default:
            begin
                cr = C_W'(D_FULL); cg = p1_reg; cb = q2;
            end
        endcase
    end

    always_comb
    begin
        mr   = 35'(cr2_reg) * 35'(255);
        mg   = 35'(cg2_reg) * 35'(255);
        mb   = 35'(cb2_reg) * 35'(255);
        araw = 16'(ap2_reg >> 15);
    end

    always_comb
    begin
        nr = 24'(lr3_reg) * 24'(DIV15_MUL);
        ng = 24'(lg3_reg) * 24'(DIV15_MUL);
        nb = 24'(lb3_reg) * 24'(DIV15_MUL);
        if (out3_reg)
            rgba_next = '0;
        else
        begin
            rgba_next.red   = 8'(nr >> 15);
            rgba_next.green = 8'(ng >> 15);
            rgba_next.blue  = 8'(nb >> 15);
            rgba_next.alpha = a3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec0_reg <= sector_t'(sec);
            f0_reg   <= fw[F_W-1:0];
            s0_reg   <= sat;
            out0_reg <= outside;

            sec1_reg <= sec0_reg;
            sf1_reg  <= C_W'(s0_reg) * C_W'(f0_reg);
            sg1_reg  <= C_W'(s0_reg) * C_W'(F_W'(SECTOR) - f0_reg);
            p1_reg   <= C_W'(am) * C_W'(SECTOR);
            am1_reg  <= am;
            rim1_reg <= s0_reg > QW'(RIM_LIMIT);
            out1_reg <= out0_reg;

            cr2_reg  <= cr;
            cg2_reg  <= cg;
            cb2_reg  <= cb;
            ap2_reg  <= 31'(am1_reg) * 31'(ALPHA_SCALE);
            rim2_reg <= rim1_reg;
            out2_reg <= out1_reg;

            lr3_reg  <= LVL_W'(mr >> 23);
            lg3_reg  <= LVL_W'(mg >> 23);
            lb3_reg  <= LVL_W'(mb >> 23);
            if (!rim2_reg || araw > 16'd255)
                a3_reg <= 8'hFF;
            else
                a3_reg <= araw[7:0];
            out3_reg <= out2_reg;

            rgba_reg <= rgba_next;
        end
    end

    assign rgba = rgba_reg;

endmodule
`default_nettype wire

// ===== rtl/hcw_checker.sv =====
// Port-level checker for the color wheel pipeline, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hcw_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pix_ready,
    input  logic           rgba_valid,
    input  logic           rgba_ready,
    input  hcw_pkg::rgba_t rgba
);
    import hcw_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rgba_valid && !rgba_ready |=> rgba_valid)
        else $error("rgba word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rgba_valid && !rgba_ready |=> $stable(rgba))
        else $error("rgba word changed while stalled");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rgba_valid |-> pix_ready)
        else $error("input blocked with empty output");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        rgba_valid && !rgba_ready |-> !pix_ready)
        else $error("input taken while pipeline stalled");

endmodule

bind hsv_color_wheel_pixel hcw_checker u_hcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_ready  (pix_ready),
    .rgba_valid (rgba_valid),
    .rgba_ready (rgba_ready),
    .rgba       (rgba)
);
`default_nettype wire
